// File: rtl/fcspq_pkg.sv
package fcspq_pkg;

  // sizing
  localparam int CAPACITY    = 64;
  localparam int NUM_CLASSES = 5;
  localparam int ID_BITS     = 16;

  // fixed field widths
  localparam int CLASS_W  = 3;
  localparam int STATUS_W = 2;

  // derived widths
  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = NUM_CLASSES * CAPACITY;
  localparam int ADDR_W = $clog2(DEPTH);

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // pointer update request from the sequencer
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [CIDX_W-1:0] enq_idx;
  } ptr_req_t;

  // pointer file view back to the sequencer
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CIDX_W-1:0] deq_idx;
    logic [ADDR_W-1:0] enq_addr;
    logic [ADDR_W-1:0] deq_addr;
    logic [CNT_W-1:0]  total;
  } ptr_view_t;

endpackage

// File: rtl/fcspq_ram.sv
module fcspq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fcspq_ptrs.sv
module fcspq_ptrs (
  input  logic                 clk,
  input  logic                 rst,
  input  fcspq_pkg::ptr_req_t  req,
  output fcspq_pkg::ptr_view_t view
);
  import fcspq_pkg::*;

  logic [SLOT_W-1:0] head  [NUM_CLASSES];
  logic [SLOT_W-1:0] tail  [NUM_CLASSES];
  logic [CNT_W-1:0]  count [NUM_CLASSES];
  logic [CNT_W-1:0]  total;

  logic [NUM_CLASSES-1:0] nonempty;
  logic [CIDX_W-1:0]      deq_idx;
  logic                   any;
  logic [SLOT_W-1:0]      enq_slot;
  logic [SLOT_W-1:0]      deq_slot;

  // wrap-around increment of a slot pointer
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    if (p == SLOT_W'(CAPACITY - 1)) begin
      return '0;
    end
    return p + SLOT_W'(1);
  endfunction

  // priority encoder: most urgent non-empty class
  always_comb begin
    deq_idx = '0;
    any     = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      nonempty[c] = (count[c] != '0);
      if (nonempty[c]) begin
        deq_idx = CIDX_W'(c);
        any     = 1'b1;
      end
    end
  end

  assign enq_slot = tail[req.enq_idx];
  assign deq_slot = head[deq_idx];

  always_comb begin
    view.full     = (total == CNT_W'(CAPACITY));
    view.empty    = !any;
    view.deq_idx  = deq_idx;
    view.enq_addr = ADDR_W'(req.enq_idx) * ADDR_W'(CAPACITY) + ADDR_W'(enq_slot);
    view.deq_addr = ADDR_W'(deq_idx) * ADDR_W'(CAPACITY) + ADDR_W'(deq_slot);
    view.total    = total;
  end

  // pointer and count update; one operation per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
      total <= '0;
    end else if (req.enq) begin
      tail[req.enq_idx]  <= next_slot(enq_slot);
      count[req.enq_idx] <= count[req.enq_idx] + CNT_W'(1);
      total              <= total + CNT_W'(1);
    end else if (req.deq) begin
      head[deq_idx]  <= next_slot(deq_slot);
      count[deq_idx] <= count[deq_idx] - CNT_W'(1);
      total          <= total - CNT_W'(1);
    end
  end

endmodule

// File: rtl/five_class_stable_priority_queue.sv
// Timing: enqueue and failed operations give their result word in the cycle after
// acceptance; a successful dequeue gives it through the registered read of the entry
// memory and then the result register; throughput is one word per cycle for enqueues
// while out_stall is not holding a result, and a dequeue stalls the next word in S_READ.
// Reset (rst, synchronous): all classes empty, internal counts zero, no result pending;
// entry memory contents and the result word registers are not cleared.
module five_class_stable_priority_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [fcspq_pkg::ID_BITS-1:0]      entry_id,
  input  logic [fcspq_pkg::CLASS_W-1:0]      risk_class,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fcspq_pkg::STATUS_W-1:0]     status,
  output logic [fcspq_pkg::ID_BITS-1:0]      out_id,
  output logic [fcspq_pkg::CLASS_W-1:0]      out_class,
  output logic [fcspq_pkg::CNT_W-1:0]        occupancy
);
  import fcspq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state, state_next;

  ptr_req_t  req;
  ptr_view_t view;

  logic               accept;
  logic               enq_go;
  logic               deq_go;
  logic [CIDX_W-1:0]  enq_idx;
  logic [ID_BITS-1:0] rdata;
  logic [CLASS_W-1:0] pend_class;

  // out-of-range classes fall to the least urgent one
  always_comb begin
    if (risk_class == '0 || risk_class > CLASS_W'(NUM_CLASSES)) begin
      enq_idx = CIDX_W'(NUM_CLASSES - 1);
    end else begin
      enq_idx = CIDX_W'(risk_class - CLASS_W'(1));
    end
  end

  // handshake: one word in flight, output register must be free
  assign in_stall = (state == S_READ) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign enq_go   = accept && (operation == OP_ENQ) && !view.full;
  assign deq_go   = accept && (operation == OP_DEQ) && !view.empty;

  always_comb begin
    req.enq     = enq_go;
    req.deq     = deq_go;
    req.enq_idx = enq_idx;
  end

  fcspq_ptrs u_ptrs (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .view (view)
  );

  fcspq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (enq_go),
    .waddr (view.enq_addr),
    .wdata (entry_id),
    .re    (deq_go),
    .raddr (view.deq_addr),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (deq_go) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_READ || (accept && !deq_go)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (deq_go) begin
      pend_class <= CLASS_W'(view.deq_idx) + CLASS_W'(1);
    end
    if (state == S_READ) begin
      status    <= ST_DONE;
      out_id    <= rdata;
      out_class <= pend_class;
      occupancy <= view.total;
    end else if (accept && !deq_go) begin
      out_id    <= '0;
      out_class <= '0;
      if (operation == OP_DEQ) begin
        status    <= ST_EMPTY;
        occupancy <= view.total;
      end else if (view.full) begin
        status    <= ST_FULL;
        occupancy <= view.total;
      end else begin
        status    <= ST_DONE;
        occupancy <= view.total + CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/fcspq_checker.sv
module fcspq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [fcspq_pkg::STATUS_W-1:0] status,
  input logic [fcspq_pkg::ID_BITS-1:0]  out_id,
  input logic [fcspq_pkg::CLASS_W-1:0]  out_class,
  input logic [fcspq_pkg::CNT_W-1:0]    occupancy
);
  import fcspq_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a full report only when the queue is at capacity
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> occupancy == CNT_W'(CAPACITY))
    else $error("full status below capacity");

  // an empty report carries no entry and zero occupancy
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |->
      out_id == '0 && out_class == '0 && occupancy == '0)
    else $error("empty status with data or occupancy");

  // a removed entry leaves room behind it
  a_deq_room: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_class != '0 |->
      status == ST_DONE && occupancy != CNT_W'(CAPACITY))
    else $error("dequeue result inconsistent");

endmodule

bind five_class_stable_priority_queue fcspq_checker u_fcspq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_id    (out_id),
  .out_class (out_class),
  .occupancy (occupancy)
);

// File: dv/testbench.sv
import fcspq_pkg::*;

// Scoreboard: keeps its own copy of the per-class queues and the expected result words
class pq_scoreboard;
  logic [ID_BITS-1:0]  id_store [NUM_CLASSES][CAPACITY];
  int unsigned         head_slot [NUM_CLASSES];
  int unsigned         tail_slot [NUM_CLASSES];
  int unsigned         held [NUM_CLASSES];
  int unsigned         held_total;
  logic [STATUS_W-1:0] want_status [$];
  logic [ID_BITS-1:0]  want_id [$];
  logic [CLASS_W-1:0]  want_class [$];
  logic [CNT_W-1:0]    want_occ [$];
  int unsigned         errors;

  function new();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_slot[c] = 0;
      tail_slot[c] = 0;
      held[c]      = 0;
    end
    held_total = 0;
    errors     = 0;
  endfunction

  function int unsigned outstanding();
    return want_status.size();
  endfunction

  // Apply one accepted request word and queue the result word it should give
  function void apply_request(logic op, logic [ID_BITS-1:0] id, logic [CLASS_W-1:0] cls);
    logic [STATUS_W-1:0] st;
    logic [ID_BITS-1:0]  rid;
    logic [CLASS_W-1:0]  rcls;
    int                  c;
    st   = ST_DONE;
    rid  = '0;
    rcls = '0;
    c    = -1;
    if (op == OP_ENQ) begin
      if (held_total >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        // out-of-range class falls to the least urgent one
        c = (cls < 1 || cls > NUM_CLASSES) ? NUM_CLASSES - 1 : int'(cls) - 1;
        id_store[c][tail_slot[c]] = id;
        tail_slot[c] = (tail_slot[c] + 1 >= CAPACITY) ? 0 : tail_slot[c] + 1;
        held[c]++;
        held_total++;
      end
    end else begin
      // most urgent non-empty class wins
      for (int k = NUM_CLASSES - 1; k >= 0; k--)
        if (held[k] != 0) c = k;
      if (c < 0) begin
        st = ST_EMPTY;
      end else begin
        rid  = id_store[c][head_slot[c]];
        rcls = CLASS_W'(c + 1);
        head_slot[c] = (head_slot[c] + 1 >= CAPACITY) ? 0 : head_slot[c] + 1;
        held[c]--;
        held_total--;
      end
    end
    want_status.push_back(st);
    want_id.push_back(rid);
    want_class.push_back(rcls);
    want_occ.push_back(CNT_W'(held_total));
  endfunction

  // Compare one accepted result word with the oldest expectation
  function void check_result(logic [STATUS_W-1:0] st, logic [ID_BITS-1:0] id,
                             logic [CLASS_W-1:0] cls, logic [CNT_W-1:0] occ);
    logic [STATUS_W-1:0] e_st;
    logic [ID_BITS-1:0]  e_id;
    logic [CLASS_W-1:0]  e_cls;
    logic [CNT_W-1:0]    e_occ;
    if (want_status.size() == 0) begin
      $error("result word with nothing outstanding: status %0d out_id %0h", st, id);
      errors++;
      return;
    end
    e_st  = want_status.pop_front();
    e_id  = want_id.pop_front();
    e_cls = want_class.pop_front();
    e_occ = want_occ.pop_front();
    if (st !== e_st) begin
      $error("status: expected %0d, got %0d", e_st, st);
      errors++;
    end
    if (id !== e_id) begin
      $error("out_id: expected %0h, got %0h", e_id, id);
      errors++;
    end
    if (cls !== e_cls) begin
      $error("out_class: expected %0d, got %0d", e_cls, cls);
      errors++;
    end
    if (occ !== e_occ) begin
      $error("occupancy: expected %0d, got %0d", e_occ, occ);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                operation;
  logic [ID_BITS-1:0]  entry_id;
  logic [CLASS_W-1:0]  risk_class;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [ID_BITS-1:0]  out_id;
  logic [CLASS_W-1:0]  out_class;
  logic [CNT_W-1:0]    occupancy;

  pq_scoreboard sb;
  logic         steady;
  int unsigned  sent;

  five_class_stable_priority_queue i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .entry_id   (entry_id),
    .risk_class (risk_class),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_id     (out_id),
    .out_class  (out_class),
    .occupancy  (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor: values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.apply_request(operation, entry_id, risk_class);
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, out_id, out_class, occupancy);
  end

  // Receiver back-pressure: free stretches, short stalls, the odd long one
  initial begin
    int unsigned hold_left;
    int unsigned r;
    logic        level;
    hold_left = 0;
    level     = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          level     = 1'b0;
          hold_left = $urandom_range(1, 30);
        end else if (r < 93) begin
          level     = 1'b1;
          hold_left = $urandom_range(1, 3);
        end else begin
          level     = 1'b1;
          hold_left = $urandom_range(10, 40);
        end
      end
      hold_left--;
      out_stall <= level && !steady;
    end
  end

  // Present one word from a falling edge and hold it until taken
  task automatic send_word(input logic op, input logic [ID_BITS-1:0] id,
                           input logic [CLASS_W-1:0] cls);
    in_valid   <= 1'b1;
    operation  <= op;
    entry_id   <= id;
    risk_class <= cls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic idle_sender(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hold the sender off until every outstanding result word is back
  task automatic drain_results();
    idle_sender(1);
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int unsigned        enq_pct;
    int unsigned        span;
    int unsigned        r;
    int unsigned        phase;
    logic               narrow;
    logic [CLASS_W-1:0] favourite;
    logic               op;
    logic [ID_BITS-1:0] id;
    logic [CLASS_W-1:0] cls;

    sb         = new();
    sent       = 0;
    steady     = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_ENQ;
    entry_id   = '0;
    risk_class = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty dequeue, every class incl. out-of-range ones, id extremes
    send_word(OP_DEQ, 16'hFFFF, 3'd7);
    send_word(OP_ENQ, 16'h0000, 3'd1);
    send_word(OP_ENQ, 16'hFFFF, 3'd5);
    send_word(OP_ENQ, 16'h1234, 3'd0);
    send_word(OP_ENQ, 16'h5A5A, 3'd6);
    send_word(OP_ENQ, 16'hA5A5, 3'd7);
    send_word(OP_ENQ, 16'hAAAA, 3'd3);
    send_word(OP_ENQ, 16'h5555, 3'd2);
    send_word(OP_ENQ, 16'h8001, 3'd1);
    send_word(OP_ENQ, 16'h7FFE, 3'd3);
    send_word(OP_ENQ, 16'h0F0F, 3'd4);
    repeat (11) send_word(OP_DEQ, 16'h0000, 3'd0);
    drain_results();

    // random phases: filling ones mostly enqueue, draining ones mostly dequeue
    phase = 0;
    while (sent < 1250) begin
      r = $urandom_range(0, 2);
      if (r == 0) begin
        enq_pct = 90;
        span    = $urandom_range(80, 150);
      end else if (r == 1) begin
        enq_pct = 15;
        span    = $urandom_range(40, 120);
      end else begin
        enq_pct = 50;
        span    = $urandom_range(30, 100);
      end
      steady    = ($urandom_range(0, 4) == 0);
      narrow    = ($urandom_range(0, 2) == 0);
      favourite = CLASS_W'($urandom_range(1, NUM_CLASSES));
      repeat (span) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        r  = $urandom_range(0, 99);
        if (r < 5)       id = '0;
        else if (r < 10) id = '1;
        else             id = ID_BITS'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (narrow && r < 70) cls = favourite;
        else if (r < 10)      cls = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
        else                  cls = CLASS_W'($urandom_range(1, NUM_CLASSES));
        send_word(op, id, cls);
        idle_sender(pick_gap());
      end
      if (phase == 0 || $urandom_range(0, 3) == 0)
        drain_results();
      phase++;
    end
    steady = 1'b0;

    // wind down
    idle_sender(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: sim.f
rtl/fcspq_pkg.sv
rtl/fcspq_ram.sv
rtl/fcspq_ptrs.sv
rtl/five_class_stable_priority_queue.sv
rtl/fcspq_checker.sv
dv/testbench.sv
